FILE: hdl/psched_pkg.sv
// shared types, codes and helpers of the process scheduler
`timescale 1ns / 1ps
`default_nettype none
package psched_pkg;

  localparam int ID_W    = 8;
  localparam int ADDR_W  = 10;
  localparam int LINES_W = 11;
  localparam int SCORE_W = 10;
  localparam int KEY_W   = 11;

  // longest program a process may carry
  localparam logic [LINES_W-1:0] LINES_MAX = 11'd1024;

  // request opcodes
  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_RR    = 2'd2,
    POL_AGING = 2'd3
  } policy_e;

  // one ready queue entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ADDR_W-1:0]  next_line;
    logic [LINES_W-1:0] remaining;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD  = 3'd0,
    CMD_ENQ   = 3'd1,
    CMD_SORT  = 3'd2,
    CMD_ISSUE = 3'd3,
    CMD_AGE   = 3'd4
  } cmd_e;

  // control broadcast to every cell of the queue
  typedef struct packed {
    cmd_e   cmd;
    logic   phase;      // odd-even sort phase
    logic   key_score;  // sort by score instead of remaining lines
    logic   shift;      // head leaves position zero
    logic   rotate;     // head goes to the tail
    entry_t head;       // updated head entry
    entry_t enq;        // entry to append
  } cell_ctrl_t;

  // sort key of an entry
  function automatic logic [KEY_W-1:0] sort_key(entry_t e, logic key_score);
    logic [KEY_W-1:0] k;
    if (key_score) begin
      k = {1'b0, e.score};
    end else begin
      k = e.remaining;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/psched_req_if.sv
// request channel of the process scheduler
`timescale 1ns / 1ps
`default_nettype none
interface psched_req_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [psched_pkg::ID_W-1:0]        proc_id;
  logic [psched_pkg::ADDR_W-1:0]      start_address;
  logic [psched_pkg::LINES_W-1:0]     line_count;
  logic [psched_pkg::SCORE_W-1:0]     initial_score;

  modport source (
    output valid, op, proc_id, start_address, line_count, initial_score,
    input  ready
  );
  modport sink (
    input  valid, op, proc_id, start_address, line_count, initial_score,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/psched_rsp_if.sv
// result channel of the process scheduler
`timescale 1ns / 1ps
`default_nettype none
interface psched_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          line_issued;
  logic [psched_pkg::ID_W-1:0]   run_id;
  logic [psched_pkg::ADDR_W-1:0] line_address;
  logic                          process_done;
  logic                          queue_full;

  modport source (
    output valid, line_issued, run_id, line_address, process_done, queue_full,
    input  ready
  );
  modport sink (
    input  valid, line_issued, run_id, line_address, process_done, queue_full,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/psched_cfg_if.sv
// policy register write channel of the process scheduler
`timescale 1ns / 1ps
`default_nettype none
interface psched_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] policy_mode;

  modport source (
    output valid, policy_mode,
    input  ready
  );
  modport sink (
    input  valid, policy_mode,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/psched_cell.sv
// one queue position: holds an entry, sorts, shifts and ages with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module psched_cell #(
  parameter int IDX = 0
) (
  input  wire logic                   clk_i,
  input  wire psched_pkg::cell_ctrl_t ctrl_i,
  input  wire psched_pkg::entry_t     lft_i,
  input  wire psched_pkg::entry_t     rgt_i,
  input  wire logic                   act_i,
  input  wire logic                   nxt_act_i,
  input  wire logic                   enq_sel_i,
  input  wire logic                   last_i,
  output psched_pkg::entry_t          ent_o
);

  localparam logic HAS_LFT = (IDX > 0);
  localparam logic PAR     = 1'((IDX % 2) != 0);

  psched_pkg::entry_t ent_q, ent_d;
  logic [psched_pkg::KEY_W-1:0] own_k, lft_k, rgt_k;
  logic is_right, is_left;

  assign own_k = psched_pkg::sort_key(ent_q, ctrl_i.key_score);
  assign lft_k = psched_pkg::sort_key(lft_i, ctrl_i.key_score);
  assign rgt_k = psched_pkg::sort_key(rgt_i, ctrl_i.key_score);

  // pair roles in the current odd-even phase
  assign is_right = HAS_LFT && act_i && (PAR ^ ctrl_i.phase);
  assign is_left  = !(PAR ^ ctrl_i.phase) && nxt_act_i;

  // next entry
  always_comb begin
    ent_d = ent_q;
    unique case (ctrl_i.cmd)
      psched_pkg::CMD_ENQ: begin
        if (enq_sel_i) ent_d = ctrl_i.enq;
      end
      psched_pkg::CMD_SORT: begin
        // swap only strictly out of order pairs, keeps equal keys stable
        if (is_right && (lft_k > own_k)) begin
          ent_d = lft_i;
        end else if (is_left && (own_k > rgt_k)) begin
          ent_d = rgt_i;
        end
      end
      psched_pkg::CMD_ISSUE: begin
        if (ctrl_i.shift) begin
          if (nxt_act_i) begin
            ent_d = rgt_i;
          end else if (last_i && ctrl_i.rotate) begin
            ent_d = ctrl_i.head;
          end
        end else if (!HAS_LFT) begin
          ent_d = ctrl_i.head;
        end
      end
      psched_pkg::CMD_AGE: begin
        if (HAS_LFT && act_i && (ent_q.score != '0)) begin
          ent_d.score = ent_q.score - psched_pkg::SCORE_W'(1);
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

FILE: hdl/process_scheduler_fcfs_sjf_rr_aging.sv
// top level of the ready queue process scheduler
// Usage: requests arrive on req_i. op ENQ appends a process (id, start address,
// line count, aging score) at the queue tail; op STEP issues one program line of
// the head process under the policy held in the register written over cfg_i
// (FCFS, SJF, round robin with a TIME_SLICE line slice, aging).
// Every request gives exactly one result on rsp_o: the issued line, its process
// id, a done flag when the process finished and left the queue, or a full flag
// when an enqueue was refused.
// The queue is a row of MAX_PROCS cells; each cell talks only to its neighbors.
// Sorting is an odd-even transposition pass per cycle, MAX_PROCS passes.
// Steps per request: an enqueue or a step on an empty queue goes straight to the
// done state; other steps issue one line; SJF and aging first sort the queue on the
// first step after an accepted enqueue or a policy write, and aging then ages the
// queue and sorts it again.
// One request is worked on at a time; a new request is taken while the previous
// result still sits in the output register.
// When the receiver stalls, the result stays in the output register and the
// next request waits in its last cycle until the register frees.
// Reset empties the queue, selects FCFS and clears the slice count; queue
// entries themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module process_scheduler_fcfs_sjf_rr_aging #(
  parameter int MAX_PROCS  = 8,
  parameter int TIME_SLICE = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  psched_req_if.sink    req_i,
  psched_rsp_if.source  rsp_o,
  psched_cfg_if.sink    cfg_i
);

  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int PASS_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int SLICE_W = $clog2(TIME_SLICE + 1);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_PROCS);
  localparam logic [PASS_W-1:0]  PASS_LAST = PASS_W'(MAX_PROCS - 1);
  localparam logic [SLICE_W-1:0] SLICE_LEN = SLICE_W'(TIME_SLICE);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SORT_PRE  = 6'b000010,
    S_ISSUE     = 6'b000100,
    S_AGE       = 6'b001000,
    S_SORT_POST = 6'b010000,
    S_DONE      = 6'b100000
  } state_e;

  typedef struct packed {
    logic                          line_issued;
    logic [psched_pkg::ID_W-1:0]   run_id;
    logic [psched_pkg::ADDR_W-1:0] line_address;
    logic                          process_done;
    logic                          queue_full;
  } res_t;

  state_e              state_q, state_d;
  psched_pkg::policy_e mode_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SLICE_W-1:0]  slice_q, slice_d, slice_inc;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic                prep_q, prep_d;
  res_t                pend_q, pend_d, out_q;
  logic                out_valid_q;

  psched_pkg::entry_t     ent [MAX_PROCS];
  psched_pkg::entry_t     lft [MAX_PROCS];
  psched_pkg::entry_t     rgt [MAX_PROCS];
  logic [MAX_PROCS-1:0]   act, nxt_act, enq_sel, last;
  psched_pkg::cell_ctrl_t ctrl;
  psched_pkg::entry_t     enq_ent, head_upd;
  logic                   head_done, rotate, req_acc, cfg_acc, out_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  // entry to append, line count clamped to 1..1024
  always_comb begin
    enq_ent.id        = req_i.proc_id;
    enq_ent.next_line = req_i.start_address;
    enq_ent.score     = req_i.initial_score;
    if (req_i.line_count == '0) begin
      enq_ent.remaining = psched_pkg::LINES_W'(1);
    end else if (req_i.line_count > psched_pkg::LINES_MAX) begin
      enq_ent.remaining = psched_pkg::LINES_MAX;
    end else begin
      enq_ent.remaining = req_i.line_count;
    end
  end

  // head after issuing one line
  always_comb begin
    head_upd           = ent[0];
    head_upd.next_line = ent[0].next_line + psched_pkg::ADDR_W'(1);
    head_upd.remaining = ent[0].remaining - psched_pkg::LINES_W'(1);
  end
  assign head_done = (ent[0].remaining <= psched_pkg::LINES_W'(1));
  assign slice_inc = slice_q + SLICE_W'(1);
  assign rotate    = !head_done && (mode_q == psched_pkg::POL_RR) && (slice_inc >= SLICE_LEN);

  // sequencer
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    slice_d        = slice_q;
    pass_d         = pass_q;
    prep_d         = prep_q;
    pend_d         = pend_q;
    ctrl.cmd       = psched_pkg::CMD_HOLD;
    ctrl.phase     = pass_q[0];
    ctrl.key_score = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.rotate    = 1'b0;
    ctrl.head      = head_upd;
    ctrl.enq       = enq_ent;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          pend_d = '0;
          if (req_i.op == psched_pkg::OP_ENQ) begin
            if (count_q == CNT_MAX) begin
              pend_d.queue_full = 1'b1;
            end else begin
              ctrl.cmd = psched_pkg::CMD_ENQ;
              count_d  = count_q + CNT_W'(1);
              prep_d   = 1'b0;
            end
            state_d = S_DONE;
          end else if (count_q == '0) begin
            state_d = S_DONE;
          end else begin
            if (mode_q != psched_pkg::POL_RR) slice_d = '0;
            pass_d = '0;
            if (!prep_q && ((mode_q == psched_pkg::POL_SJF) ||
                            (mode_q == psched_pkg::POL_AGING))) begin
              state_d = S_SORT_PRE;
            end else begin
              state_d = S_ISSUE;
            end
          end
        end
      end
      S_SORT_PRE: begin
        ctrl.cmd       = psched_pkg::CMD_SORT;
        ctrl.key_score = (mode_q == psched_pkg::POL_AGING);
        pass_d         = pass_q + PASS_W'(1);
        if (pass_q == PASS_LAST) state_d = S_ISSUE;
      end
      S_ISSUE: begin
        ctrl.cmd            = psched_pkg::CMD_ISSUE;
        ctrl.shift          = head_done || rotate;
        ctrl.rotate         = rotate;
        prep_d              = 1'b1;
        pend_d.line_issued  = 1'b1;
        pend_d.run_id       = ent[0].id;
        pend_d.line_address = ent[0].next_line;
        pend_d.process_done = head_done;
        pend_d.queue_full   = 1'b0;
        if (head_done) begin
          count_d = count_q - CNT_W'(1);
          slice_d = '0;
        end else if (mode_q == psched_pkg::POL_RR) begin
          slice_d = rotate ? '0 : slice_inc;
        end
        state_d = (mode_q == psched_pkg::POL_AGING) ? S_AGE : S_DONE;
      end
      S_AGE: begin
        ctrl.cmd = psched_pkg::CMD_AGE;
        pass_d   = '0;
        state_d  = S_SORT_POST;
      end
      S_SORT_POST: begin
        ctrl.cmd       = psched_pkg::CMD_SORT;
        ctrl.key_score = 1'b1;
        pass_d         = pass_q + PASS_W'(1);
        if (pass_q == PASS_LAST) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= psched_pkg::POL_FCFS;
      count_q     <= '0;
      slice_q     <= '0;
      pass_q      <= '0;
      prep_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      slice_q <= slice_d;
      pass_q  <= pass_d;
      if (cfg_acc) begin
        mode_q <= psched_pkg::policy_e'(cfg_i.policy_mode);
        prep_q <= 1'b0;
      end else begin
        prep_q <= prep_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) out_q <= pend_q;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.line_issued  = out_q.line_issued;
  assign rsp_o.run_id       = out_q.run_id;
  assign rsp_o.line_address = out_q.line_address;
  assign rsp_o.process_done = out_q.process_done;
  assign rsp_o.queue_full   = out_q.queue_full;

  // row of queue cells
  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    assign act[i]     = (CNT_W'(i) < count_q);
    assign nxt_act[i] = (CNT_W'(i + 1) < count_q);
    assign enq_sel[i] = (count_q == CNT_W'(i));
    assign last[i]    = (count_q == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign lft[i] = ent[i];
    end else begin : g_mid_l
      assign lft[i] = ent[i-1];
    end
    if (i == MAX_PROCS - 1) begin : g_last
      assign rgt[i] = ent[i];
    end else begin : g_mid_r
      assign rgt[i] = ent[i+1];
    end

    psched_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .lft_i     (lft[i]),
      .rgt_i     (rgt[i]),
      .act_i     (act[i]),
      .nxt_act_i (nxt_act[i]),
      .enq_sel_i (enq_sel[i]),
      .last_i    (last[i]),
      .ent_o     (ent[i])
    );
  end

endmodule
`default_nettype wire

FILE: bench/tb_process_scheduler_fcfs_sjf_rr_aging.sv
// self-checking bench for the ready queue process scheduler across all four policies
`timescale 1ns / 1ps
module tb_process_scheduler_fcfs_sjf_rr_aging;

  localparam int MAX_PROCS   = 8;
  localparam int TIME_SLICE  = 2;
  localparam int PHASE_REQS  = 92;
  localparam int CYCLE_LIMIT = 400000;

  // one request as queued for the driver
  typedef struct {
    logic                           op;
    logic [psched_pkg::ID_W-1:0]    proc_id;
    logic [psched_pkg::ADDR_W-1:0]  start_address;
    logic [psched_pkg::LINES_W-1:0] line_count;
    logic [psched_pkg::SCORE_W-1:0] initial_score;
    bit                             wait_idle;
  } sched_req_t;

  // one predicted result
  typedef struct packed {
    logic                          issued;
    logic [psched_pkg::ID_W-1:0]   run_id;
    logic [psched_pkg::ADDR_W-1:0] addr;
    logic                          done;
    logic                          full;
  } line_grant_t;

  logic clk_i;
  logic rst_ni;

  psched_req_if req_if ();
  psched_rsp_if rsp_if ();
  psched_cfg_if cfg_if ();

  process_scheduler_fcfs_sjf_rr_aging #(
    .MAX_PROCS  (MAX_PROCS),
    .TIME_SLICE (TIME_SLICE)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  sched_req_t  pending_reqs[$];
  line_grant_t granted_lines[$];
  int unsigned reqs_queued;
  int unsigned reqs_accepted;
  int unsigned results_seen;
  int unsigned error_count;

  // shadow of the scheduler state
  psched_pkg::entry_t  rq_entries[MAX_PROCS];
  int                  rq_len;
  int                  rr_slice;
  bit                  rq_sorted;
  psched_pkg::policy_e cur_policy;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(CYCLE_LIMIT * 4);
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ordering key: score for aging, lines left otherwise
  function automatic logic [psched_pkg::LINES_W-1:0] rank_of(psched_pkg::entry_t e,
                                                             bit by_score);
    return by_score ? {1'b0, e.score} : e.remaining;
  endfunction

  // stable insertion sort of the shadow queue
  function automatic void sort_ready_queue(bit by_score);
    psched_pkg::entry_t tmp;
    int                 i;
    int                 j;
    for (i = 1; i < rq_len; i++) begin
      j = i;
      while (j > 0 && rank_of(rq_entries[j-1], by_score) > rank_of(rq_entries[j], by_score)) begin
        tmp             = rq_entries[j-1];
        rq_entries[j-1] = rq_entries[j];
        rq_entries[j]   = tmp;
        j--;
      end
    end
  endfunction

  // head leaves position zero, to the tail or out of the queue
  function automatic void pop_head(bit to_tail);
    psched_pkg::entry_t head;
    int                 i;
    head = rq_entries[0];
    for (i = 0; i + 1 < rq_len; i++) rq_entries[i] = rq_entries[i+1];
    if (to_tail) begin
      rq_entries[rq_len-1] = head;
    end else begin
      rq_len--;
    end
  endfunction

  // advance the shadow scheduler by one request and return its result
  function automatic line_grant_t schedule_request(sched_req_t r);
    line_grant_t                    g;
    logic [psched_pkg::LINES_W-1:0] len;
    int                             i;
    g = '0;
    if (r.op == psched_pkg::OP_ENQ) begin
      if (rq_len >= MAX_PROCS) begin
        g.full = 1'b1;
      end else begin
        len = r.line_count;
        if (len == '0) len = psched_pkg::LINES_W'(1);
        if (len > psched_pkg::LINES_MAX) len = psched_pkg::LINES_MAX;
        rq_entries[rq_len] = '{id: r.proc_id, next_line: r.start_address,
                               remaining: len, score: r.initial_score};
        rq_len++;
        rq_sorted = 1'b0;
      end
    end else if (rq_len != 0) begin
      if (cur_policy != psched_pkg::POL_RR) rr_slice = 0;
      if (!rq_sorted) begin
        if (cur_policy == psched_pkg::POL_SJF) sort_ready_queue(1'b0);
        else if (cur_policy == psched_pkg::POL_AGING) sort_ready_queue(1'b1);
        rq_sorted = 1'b1;
      end
      g.issued = 1'b1;
      g.run_id = rq_entries[0].id;
      g.addr   = rq_entries[0].next_line;
      rq_entries[0].next_line = rq_entries[0].next_line + 1'b1;
      if (rq_entries[0].remaining != '0) rq_entries[0].remaining--;
      if (rq_entries[0].remaining == '0) begin
        g.done = 1'b1;
        pop_head(1'b0);
        rr_slice = 0;
      end else if (cur_policy == psched_pkg::POL_RR) begin
        rr_slice++;
        if (rr_slice >= TIME_SLICE) begin
          pop_head(1'b1);
          rr_slice = 0;
        end
      end
      // age everyone behind the head, then reorder
      if (cur_policy == psched_pkg::POL_AGING) begin
        for (i = 1; i < rq_len; i++)
          if (rq_entries[i].score != '0) rq_entries[i].score--;
        sort_ready_queue(1'b1);
      end
    end
    return g;
  endfunction

  // mostly short programs, now and then long ones
  function automatic logic [psched_pkg::LINES_W-1:0] pick_line_count();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r == 0) return psched_pkg::LINES_W'($urandom_range(0, 2047));
    if (r < 20) return psched_pkg::LINES_W'($urandom_range(0, 63));
    return psched_pkg::LINES_W'($urandom_range(1, 4));
  endfunction

  task automatic add_enq(input logic [psched_pkg::ID_W-1:0]    id,
                         input logic [psched_pkg::ADDR_W-1:0]  addr,
                         input logic [psched_pkg::LINES_W-1:0] cnt,
                         input logic [psched_pkg::SCORE_W-1:0] score);
    sched_req_t r;
    r = '{op: psched_pkg::OP_ENQ, proc_id: id, start_address: addr, line_count: cnt,
          initial_score: score, wait_idle: 1'b0};
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic add_enq_random();
    logic [psched_pkg::SCORE_W-1:0] score;
    score = $urandom_range(0, 1) ? psched_pkg::SCORE_W'($urandom_range(0, 1023))
                                 : psched_pkg::SCORE_W'($urandom_range(0, 15));
    add_enq(psched_pkg::ID_W'($urandom_range(0, 255)),
            psched_pkg::ADDR_W'($urandom_range(0, 1023)),
            pick_line_count(), score);
  endtask

  // step request; payload is don't-care so it is randomized
  task automatic add_step();
    sched_req_t r;
    r = '{op: psched_pkg::OP_STEP, proc_id: psched_pkg::ID_W'($urandom_range(0, 255)),
          start_address: psched_pkg::ADDR_W'($urandom_range(0, 1023)),
          line_count: psched_pkg::LINES_W'($urandom_range(0, 2047)),
          initial_score: psched_pkg::SCORE_W'($urandom_range(0, 1023)), wait_idle: 1'b0};
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // wait until every request is accepted and every result checked
  task automatic wait_quiet();
    @(posedge clk_i);
    while (reqs_accepted != reqs_queued || granted_lines.size() != 0) @(posedge clk_i);
  endtask

  // write the policy register while the block is idle
  task automatic write_policy(input psched_pkg::policy_e p);
    wait_quiet();
    @(posedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.policy_mode <= p;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    cur_policy = p;
    rq_sorted  = 1'b0;
  endtask

  // random phase: well-formed enqueue/step runs, drains, overfills and noise
  task automatic queue_phase(input int unsigned n_reqs);
    int unsigned made;
    int unsigned kind;
    int unsigned k;
    int unsigned m;
    made = 0;
    while (made < n_reqs) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        k = $urandom_range(1, 4);
        m = $urandom_range(1, 8);
        repeat (k) add_enq_random();
        repeat (m) add_step();
        made += k + m;
      end else if (kind == 6) begin
        m = $urandom_range(6, 16);
        repeat (m) add_step();
        made += m;
      end else if (kind == 7) begin
        k = $urandom_range(3, 9);
        repeat (k) add_enq_random();
        made += k;
      end else begin
        if ($urandom_range(0, 1)) add_step();
        else add_enq_random();
        made++;
      end
      // occasionally hold off until the block has drained
      if ($urandom_range(0, 39) == 0) pending_reqs[pending_reqs.size()-1].wait_idle = 1'b1;
    end
  endtask

  // request driver: bursts with random gaps
  int unsigned tx_gap;
  int unsigned tx_burst;
  sched_req_t  tx_cur;
  sched_req_t  tx_nxt;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      tx_gap   = 0;
      tx_burst = $urandom_range(1, 16);
    end else begin
      // request taken at this edge
      if (req_if.valid && req_if.ready) begin
        granted_lines.push_back(schedule_request(tx_cur));
        reqs_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].wait_idle && granted_lines.size() != 0)) begin
          tx_nxt = pending_reqs.pop_front();
          tx_cur = tx_nxt;
          req_if.valid         <= 1'b1;
          req_if.op            <= tx_nxt.op;
          req_if.proc_id       <= tx_nxt.proc_id;
          req_if.start_address <= tx_nxt.start_address;
          req_if.line_count    <= tx_nxt.line_count;
          req_if.initial_score <= tx_nxt.initial_score;
          tx_burst--;
          if (tx_burst == 0) begin
            tx_burst = $urandom_range(1, 16);
            tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  int unsigned rx_cycle;
  int unsigned rx_mode;
  int unsigned rx_hold;
  line_grant_t rx_want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_cycle = 0;
      rx_mode  = 0;
      rx_hold  = 0;
    end else begin
      // compare against the oldest prediction
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (granted_lines.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing predicted", results_seen));
        end else begin
          rx_want = granted_lines.pop_front();
          if (rsp_if.line_issued !== rx_want.issued)
            report_mismatch($sformatf("result %0d line_issued %b, want %b",
                                      results_seen, rsp_if.line_issued, rx_want.issued));
          if (rsp_if.run_id !== rx_want.run_id)
            report_mismatch($sformatf("result %0d run_id %0d, want %0d",
                                      results_seen, rsp_if.run_id, rx_want.run_id));
          if (rsp_if.line_address !== rx_want.addr)
            report_mismatch($sformatf("result %0d line_address %0d, want %0d",
                                      results_seen, rsp_if.line_address, rx_want.addr));
          if (rsp_if.process_done !== rx_want.done)
            report_mismatch($sformatf("result %0d process_done %b, want %b",
                                      results_seen, rsp_if.process_done, rx_want.done));
          if (rsp_if.queue_full !== rx_want.full)
            report_mismatch($sformatf("result %0d queue_full %b, want %b",
                                      results_seen, rsp_if.queue_full, rx_want.full));
        end
      end
      // stall pattern: free-running, sparse random, or long holds
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_hold != 0) begin
        rx_hold--;
        rsp_if.ready <= 1'b0;
      end else if (rx_mode == 2 && $urandom_range(0, 15) == 0) begin
        rx_hold = $urandom_range(2, 19);
        rsp_if.ready <= 1'b0;
      end else if (rx_mode == 1) begin
        rsp_if.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.op            = psched_pkg::OP_ENQ;
    req_if.proc_id       = '0;
    req_if.start_address = '0;
    req_if.line_count    = '0;
    req_if.initial_score = '0;
    rsp_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.policy_mode   = psched_pkg::POL_FCFS;
    reqs_queued   = 0;
    reqs_accepted = 0;
    results_seen  = 0;
    error_count   = 0;
    rq_len        = 0;
    rr_slice      = 0;
    rq_sorted     = 1'b0;
    cur_policy    = psched_pkg::POL_FCFS;
    foreach (rq_entries[i]) rq_entries[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queue step, zero line count, address wrap
    add_step();
    add_enq(8'd0, 10'd1023, 11'd0, 10'd0);
    add_enq(8'd255, 10'd1022, 11'd3, 10'd1023);
    repeat (4) add_step();

    // fill the queue, long and clamped programs included, then overflow
    add_enq(8'd1, 10'd0, 11'd5, 10'd7);
    add_enq(8'd2, 10'd512, 11'd2, 10'd1023);
    add_enq(8'd3, 10'd1020, 11'd2047, 10'd0);
    add_enq(8'd4, 10'd1023, 11'd1, 10'd5);
    add_enq(8'd5, 10'd100, 11'd1024, 10'd5);
    add_enq(8'd6, 10'd341, 11'd3, 10'd512);
    add_enq(8'd7, 10'd682, 11'd2, 10'd1);
    add_enq(8'd8, 10'd7, 11'd4, 10'd9);
    add_enq(8'd9, 10'd55, 11'd2, 10'd3);
    repeat (3) add_step();

    // one short visit to each other policy
    write_policy(psched_pkg::POL_SJF);
    repeat (2) add_step();
    write_policy(psched_pkg::POL_RR);
    repeat (2) add_step();
    write_policy(psched_pkg::POL_AGING);
    repeat (2) add_step();

    // random phases over every policy, extremes included
    write_policy(psched_pkg::POL_AGING);
    queue_phase(PHASE_REQS);
    pending_reqs[0].wait_idle = 1'b1;
    write_policy(psched_pkg::POL_FCFS);
    queue_phase(PHASE_REQS);
    write_policy(psched_pkg::POL_RR);
    queue_phase(PHASE_REQS);
    write_policy(psched_pkg::POL_SJF);
    queue_phase(PHASE_REQS);
    write_policy(psched_pkg::POL_AGING);
    queue_phase(PHASE_REQS);
    write_policy(psched_pkg::POL_FCFS);
    queue_phase(PHASE_REQS);
    write_policy(psched_pkg::POL_SJF);
    queue_phase(PHASE_REQS);
    write_policy(psched_pkg::POL_RR);
    queue_phase(PHASE_REQS);

    wait_quiet();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: process_scheduler_fcfs_sjf_rr_aging.f
hdl/psched_pkg.sv
hdl/psched_req_if.sv
hdl/psched_rsp_if.sv
hdl/psched_cfg_if.sv
hdl/psched_cell.sv
hdl/process_scheduler_fcfs_sjf_rr_aging.sv
bench/tb_process_scheduler_fcfs_sjf_rr_aging.sv
